/* hdl/mpq_pkg.sv */
package mpq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;

  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_EXTRACT = 1'b1
  } mpq_mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mpq_status_t;

  typedef struct packed {
    mpq_mode_t                 mode;
    logic signed [DataW-1:0]   value;
  } mpq_in_t;

  typedef struct packed {
    mpq_status_t               status;
    logic signed [DataW-1:0]   max_value;
    logic [CountW-1:0]         count_after;
  } mpq_out_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic                      insert;
    logic                      extract;
    logic signed [DataW-1:0]   value;
  } mpq_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      keep;
    logic signed [DataW-1:0]   value;
  } mpq_link_t;

endpackage

/* hdl/mpq_cell.sv */
module mpq_cell (
  input  logic               clk,
  input  logic               rst,
  input  mpq_pkg::mpq_op_t   op,
  input  mpq_pkg::mpq_link_t left,
  input  mpq_pkg::mpq_link_t right,
  output mpq_pkg::mpq_link_t link
);

  logic                            valid;
  logic                            valid_next;
  logic signed [mpq_pkg::DataW-1:0] value;
  logic signed [mpq_pkg::DataW-1:0] value_next;
  logic                            keep;

  // entry stays put when it is not smaller than the new word
  assign keep = valid && !(value < op.value);

  assign link.valid = valid;
  assign link.keep  = keep;
  assign link.value = value;

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (op.insert) begin
      if (!keep) begin
        if (left.keep) begin
          valid_next = 1'b1;
          value_next = op.value;
        end else begin
          valid_next = left.valid;
          value_next = left.value;
        end
      end
    end else if (op.extract) begin
      valid_next = right.valid;
      value_next = right.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

/* hdl/max_priority_queue_unit.sv */
// result: start is registered into busy, and busy into done along with the result
// a new word is taken only while busy is low; a sorted row of cells does each
//   insert or extract with all cells acting at once
// reset: synchronous; empties the queue and clears all pending work
// the receiver cannot stall: done is high for exactly one cycle per word
module max_priority_queue_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mpq_pkg::mpq_in_t  item,
  output logic              busy,
  output logic              done,
  output mpq_pkg::mpq_out_t result
);

  localparam int unsigned N = mpq_pkg::Capacity;

  logic                            pend;
  mpq_pkg::mpq_in_t                cmd;
  logic [mpq_pkg::CountW-1:0]      count;
  logic [mpq_pkg::CountW-1:0]      count_next;
  mpq_pkg::mpq_out_t               result_next;
  mpq_pkg::mpq_op_t                op;
  mpq_pkg::mpq_link_t              links [N];
  mpq_pkg::mpq_link_t              edge_left;
  mpq_pkg::mpq_link_t              edge_right;
  logic                            full;
  logic                            empty;

  assign busy  = pend;
  assign full  = (count == mpq_pkg::CountW'(N));
  assign empty = (count == '0);

  assign op.insert  = pend && (cmd.mode == mpq_pkg::MODE_INSERT) && !full;
  assign op.extract = pend && (cmd.mode == mpq_pkg::MODE_EXTRACT) && !empty;
  assign op.value   = cmd.value;

  assign edge_left  = '{valid: 1'b1, keep: 1'b1, value: '0};
  assign edge_right = '{valid: 1'b0, keep: 1'b0, value: '0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    mpq_pkg::mpq_link_t l_in;
    mpq_pkg::mpq_link_t r_in;
    if (i == 0) begin : g_first
      assign l_in = edge_left;
    end else begin : g_mid_l
      assign l_in = links[i-1];
    end
    if (i == N - 1) begin : g_last
      assign r_in = edge_right;
    end else begin : g_mid_r
      assign r_in = links[i+1];
    end
    mpq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .op    (op),
      .left  (l_in),
      .right (r_in),
      .link  (links[i])
    );
  end

  always_comb begin
    count_next              = count;
    result_next.status      = mpq_pkg::ST_DONE;
    result_next.max_value   = '0;
    if (cmd.mode == mpq_pkg::MODE_INSERT) begin
      if (full) begin
        result_next.status = mpq_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        result_next.status = mpq_pkg::ST_EMPTY;
      end else begin
        count_next            = count - 1'b1;
        result_next.max_value = links[0].value;
      end
    end
    result_next.count_after = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      pend <= start && !pend;
      done <= pend;
      if (pend) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !pend) begin
      cmd <= item;
    end
    if (pend) begin
      result <= result_next;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an operation cycle");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("operation cycle longer than one clock");

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    links[0].valid == (count != '0))
    else $error("head cell occupancy disagrees with count");

  a_tail_matches_count: assert property (@(posedge clk) disable iff (rst)
    links[N-1].valid == (count == mpq_pkg::CountW'(N)))
    else $error("tail cell occupancy disagrees with count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.count_after <= mpq_pkg::CountW'(N)))
    else $error("count beyond capacity");

endmodule
